>>> sv/kmrb_pkg.sv
// ----------------------------------------------------------------------------
// kmrb_pkg
// Shared types, constants and key map tables for the keyboard report builder.
// ----------------------------------------------------------------------------
package kmrb_pkg;

  localparam int MATRIX_ROWS    = 6;
  localparam int MATRIX_COLUMNS = 14;
  localparam int ROLL_SLOTS     = 6;
  localparam int REPORT_SLOTS   = 6;
  localparam int KEY_COUNT      = MATRIX_ROWS * MATRIX_COLUMNS;
  localparam int KEY_W          = $clog2(KEY_COUNT);
  localparam int ROM_SIZE       = 84;

  localparam logic [7:0] HID_SEMICOLON = 8'h33;

  localparam logic [1:0] LAYER_BASE = 2'd1;
  localparam logic [1:0] LAYER_FN   = 2'd2;
  localparam logic [1:0] LAYER_SEMI = 2'd3;

  localparam logic [2:0] MACRO_NONE    = 3'd0;
  localparam logic [2:0] MACRO_BRACKET = 3'd1;
  localparam logic [2:0] MACRO_QUOTE   = 3'd2;
  localparam logic [2:0] MACRO_BRACE   = 3'd3;
  localparam logic [2:0] MACRO_NEWLINE = 3'd4;
  localparam logic [2:0] MACRO_BOOT    = 3'd5;

  // keys whose held level is mirrored in flops
  localparam int SP_FN_A    = 0;
  localparam int SP_FN_B    = 1;
  localparam int SP_BRACKET = 2;
  localparam int SP_QUOTE   = 3;
  localparam int SP_BRACE   = 4;
  localparam int SP_NEWLINE = 5;
  localparam int SP_BOOT    = 6;
  localparam int SP_COUNT   = 7;

  localparam logic [6:0] SPECIAL_POS [SP_COUNT] = '{
    7'(0*6+0), 7'(6*6+0), 7'(1*6+0), 7'(2*6+0), 7'(3*6+0), 7'(4*6+0), 7'(0*6+3)
  };

  localparam logic [7:0] ROM_BASE [ROM_SIZE] = '{
    8'd0,   8'h02, 8'h01, 8'd43, 8'd46, 8'd0,
    8'd80,  8'd29, 8'd4,  8'd20, 8'd30, 8'd0,
    8'd82,  8'd27, 8'd22, 8'd26, 8'd31, 8'd0,
    8'd81,  8'd6,  8'd7,  8'd8,  8'd32, 8'd0,
    8'h08,  8'd25, 8'd9,  8'd21, 8'd33, 8'd0,
    8'd42,  8'd5,  8'd10, 8'd23, 8'd34, 8'd0,
    8'd0,   8'd40, 8'h40, 8'd41, 8'd0,  8'd0,
    8'd44,  8'd17, 8'd11, 8'd28, 8'd35, 8'd0,
    8'd80,  8'd16, 8'd13, 8'd24, 8'd36, 8'd0,
    8'd81,  8'd54, 8'd14, 8'd12, 8'd37, 8'd0,
    8'd82,  8'd55, 8'd15, 8'd18, 8'd38, 8'd0,
    8'd79,  8'd56, 8'd51, 8'd19, 8'd39, 8'd0,
    8'd101, 8'h20, 8'd52, 8'd47, 8'd45, 8'd0,
    8'd0,   8'd0,  8'd0,  8'd0,  8'd0,  8'd0
  };

  // function and semicolon layers share one table
  localparam logic [7:0] ROM_UPPER [ROM_SIZE] = '{
    8'd0,   8'h02, 8'h01, 8'd0,   8'd69, 8'd0,
    8'd0,   8'd29, 8'd129, 8'd49, 8'd58, 8'd0,
    8'd0,   8'd27, 8'd128, 8'd53, 8'd59, 8'd0,
    8'd0,   8'd6,  8'd76,  8'd8,  8'd60, 8'd0,
    8'd0,   8'd25, 8'd127, 8'd21, 8'd61, 8'd0,
    8'd42,  8'd5,  8'd10,  8'd23, 8'd62, 8'd0,
    8'd0,   8'd40, 8'h40,  8'd41, 8'd0,  8'd0,
    8'd44,  8'd74, 8'd80,  8'd28, 8'd63, 8'd0,
    8'd80,  8'd78, 8'd81,  8'd70, 8'd64, 8'd0,
    8'd81,  8'd75, 8'd82,  8'd71, 8'd65, 8'd0,
    8'd82,  8'd77, 8'd79,  8'd72, 8'd66, 8'd0,
    8'd79,  8'd56, 8'd51,  8'd19, 8'd67, 8'd0,
    8'd101, 8'h20, 8'd52,  8'd48, 8'd68, 8'd0,
    8'd0,   8'd0,  8'd0,   8'd0,  8'd0,  8'd0
  };

  typedef struct packed {
    logic [6:0] key_index;
    logic       key_level;
  } key_item_t;

  typedef struct packed {
    logic [7:0] code_slot0;
    logic [7:0] code_slot1;
    logic [7:0] code_slot2;
    logic [7:0] code_slot3;
    logic [7:0] code_slot4;
    logic [7:0] code_slot5;
    logic [7:0] modifier_bits;
    logic [2:0] macro_code;
    logic       last_of_run;
  } report_t;

  function automatic logic [7:0] rom_read(input logic [1:0] layer, input logic [6:0] pos);
    logic [7:0] val;
    val = 8'd0;
    if (32'(pos) < ROM_SIZE) begin
      val = (layer == LAYER_BASE) ? ROM_BASE[pos] : ROM_UPPER[pos];
    end
    return val;
  endfunction

  function automatic logic is_mod_key(input logic [6:0] pos);
    return pos inside {7'd0, 7'd1, 7'd2, 7'd24, 7'd36, 7'd38, 7'd72, 7'd73};
  endfunction

  function automatic report_t pack_report(input logic [REPORT_SLOTS-1:0][7:0] codes,
                                          input logic [7:0] mods,
                                          input logic [2:0] macro,
                                          input logic last);
    report_t r;
    r.code_slot0    = codes[0];
    r.code_slot1    = codes[1];
    r.code_slot2    = codes[2];
    r.code_slot3    = codes[3];
    r.code_slot4    = codes[4];
    r.code_slot5    = codes[5];
    r.modifier_bits = mods;
    r.macro_code    = macro;
    r.last_of_run   = last;
    return r;
  endfunction

endpackage

>>> sv/kmrb_ram.sv
// ----------------------------------------------------------------------------
// kmrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kmrb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 84,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/keyboard_matrix_report_builder_top.sv
// ----------------------------------------------------------------------------
// keyboard_matrix_report_builder_top
// Turns scanned key levels into HID keyboard reports with layers and macros.
// ----------------------------------------------------------------------------
// Each beat on the key channel carries one scanned key level. The held map
// lives in a small RAM: the key is looked up in the cycle it is accepted and
// the press or release is worked out in the update stage, so a new item can
// be taken every cycle while the report side keeps up. A semicolon tap gives
// two report beats, which holds the update stage while the second beat
// waits; otherwise the sustained rate is one item per cycle while the
// report side keeps up. Out of range keys and unchanged levels produce no
// beat. Held map entries that were never written read as released through
// per-entry valid flops, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyboard_matrix_report_builder_top
  import kmrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      key_valid,
  output logic      key_ready,
  input  key_item_t key_item,
  output logic      report_valid,
  input  logic      report_ready,
  output report_t   report
);

  // ---------------- lookup stage ----------------
  logic             s1_valid;
  logic [6:0]       s1_key;
  logic             s1_down;
  logic             s1_in_range;
  logic             s1_vbit;
  logic             s1_hit;
  logic             s1_fwd;
  logic             s1_fire;
  logic             ram_q;
  logic [KEY_COUNT-1:0] map_written;

  // update stage write port
  logic             map_we;
  logic             key_accept;
  logic             in_range;

  // ---------------- block state ----------------
  logic [ROLL_SLOTS-1:0][6:0]   queue, queue_next;
  logic [7:0]                   mods, mods_next;
  logic                         semi_held, semi_held_next;
  logic                         semi_used, semi_used_next;
  logic [1:0]                   layer, layer_next;
  logic [REPORT_SLOTS-1:0][7:0] sent_codes, sent_codes_next;
  logic [7:0]                   sent_mods, sent_mods_next;
  logic [SP_COUNT-1:0]          special, special_next;

  // ---------------- output stage ----------------
  logic    pend_valid;
  report_t pend_report;
  logic [1:0] nres;
  report_t res0, res1;

  assign key_accept = key_valid && key_ready;
  assign key_ready  = !s1_valid || s1_fire;
  assign in_range   = 32'(key_item.key_index) < KEY_COUNT;

  kmrb_ram #(
    .WIDTH (1),
    .DEPTH (KEY_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (s1_key[KEY_W-1:0]),
    .wdata (s1_down),
    .re    (key_accept),
    .raddr (key_item.key_index[KEY_W-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_ready) begin
      s1_valid <= key_valid;
    end
  end

  // payload of the lookup stage, plus forwarding of a write landing this cycle
  always_ff @(posedge clk) begin
    if (key_accept) begin
      s1_key      <= key_item.key_index;
      s1_down     <= key_item.key_level;
      s1_in_range <= in_range;
      s1_vbit     <= in_range ? map_written[key_item.key_index[KEY_W-1:0]] : 1'b0;
      s1_hit      <= map_we && (s1_key == key_item.key_index);
      s1_fwd      <= s1_down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_written <= '0;
    end else if (map_we) begin
      map_written[s1_key[KEY_W-1:0]] <= 1'b1;
    end
  end

  // update stage may run when the output side has room for two beats
  assign s1_fire = s1_valid && !pend_valid && (!report_valid || report_ready);

  // ---------------- press / release handling ----------------
  always_comb begin
    logic                         held_now;
    logic                         change;
    logic                         is_semi;
    logic                         do_emit;
    logic                         found;
    logic [ROLL_SLOTS:0][6:0]     q_shift;
    logic [ROLL_SLOTS:0][6:0]     q_ext;
    logic [2:0]                   macro;
    logic [REPORT_SLOTS-1:0][7:0] codes;
    logic [REPORT_SLOTS-1:0][7:0] zero_codes;

    held_now  = s1_hit ? s1_fwd : (s1_vbit & ram_q);
    change    = s1_in_range && (held_now != s1_down);
    is_semi   = rom_read(layer, s1_key) == HID_SEMICOLON;
    do_emit   = 1'b0;
    found     = 1'b0;
    q_shift   = {queue, s1_key};
    q_ext     = {7'd0, queue};
    macro     = MACRO_NONE;
    codes     = '0;
    zero_codes = '0;

    queue_next      = queue;
    mods_next       = mods;
    semi_held_next  = semi_held;
    semi_used_next  = semi_used;
    layer_next      = layer;
    sent_codes_next = sent_codes;
    sent_mods_next  = sent_mods;
    special_next    = special;
    nres            = 2'd0;
    res0            = pack_report(zero_codes, 8'd0, MACRO_NONE, 1'b1);
    res1            = res0;

    map_we = s1_fire && change;

    if (change) begin
      for (int s = 0; s < SP_COUNT; s++) begin
        if (s1_key == SPECIAL_POS[s]) begin
          special_next[s] = s1_down;
        end
      end

      if (s1_down) begin
        if (is_semi) begin
          semi_held_next = 1'b1;
          semi_used_next = 1'b0;
        end else begin
          if (semi_held) begin
            semi_used_next = 1'b1;
          end
          if (is_mod_key(s1_key)) begin
            mods_next = mods | ROM_BASE[s1_key];
          end else begin
            queue_next = q_shift[ROLL_SLOTS-1:0];
          end
          do_emit = 1'b1;
        end
      end else begin
        if (is_semi) begin
          semi_held_next = 1'b0;
          if (!semi_used) begin
            // tap: semicolon beat, then the same report with slot 0 cleared
            codes           = sent_codes;
            codes[0]        = HID_SEMICOLON;
            res0            = pack_report(codes, sent_mods, MACRO_NONE, 1'b0);
            codes[0]        = 8'd0;
            res1            = pack_report(codes, sent_mods, MACRO_NONE, 1'b1);
            sent_codes_next = codes;
            nres            = 2'd2;
          end
        end else begin
          if (is_mod_key(s1_key)) begin
            mods_next = mods & ~rom_read(layer, s1_key);
          end else begin
            // first match and everything behind it moves up one slot
            for (int j = 0; j < ROLL_SLOTS; j++) begin
              if (queue[j] == s1_key) begin
                found = 1'b1;
              end
              if (found) begin
                queue_next[j] = q_ext[j+1];
              end
            end
          end
          do_emit = 1'b1;
        end
      end
    end

    if (do_emit) begin
      if (special_next[SP_FN_A] || special_next[SP_FN_B]) begin
        layer_next = LAYER_FN;
      end else if (semi_held_next) begin
        layer_next = LAYER_SEMI;
      end else begin
        layer_next = LAYER_BASE;
      end

      if (layer_next == LAYER_FN) begin
        if (special_next[SP_BRACKET]) begin
          macro = MACRO_BRACKET;
        end else if (special_next[SP_QUOTE]) begin
          macro = MACRO_QUOTE;
        end else if (special_next[SP_BRACE]) begin
          macro = MACRO_BRACE;
        end else if (special_next[SP_NEWLINE]) begin
          macro = MACRO_NEWLINE;
        end else if (special_next[SP_BOOT]) begin
          macro = MACRO_BOOT;
        end
      end

      nres = 2'd1;
      if (macro != MACRO_NONE) begin
        // the bootloader code leaves the last report untouched
        if (macro != MACRO_BOOT) begin
          sent_codes_next = '0;
          sent_mods_next  = 8'd0;
        end
        res0 = pack_report(zero_codes, 8'd0, macro, 1'b1);
      end else begin
        for (int i = 0; i < REPORT_SLOTS; i++) begin
          if (i < ROLL_SLOTS) begin
            codes[i] = rom_read(layer_next, queue_next[i]);
          end
        end
        sent_codes_next = codes;
        sent_mods_next  = mods_next;
        res0 = pack_report(codes, mods_next, MACRO_NONE, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue      <= '0;
      mods       <= 8'd0;
      semi_held  <= 1'b0;
      semi_used  <= 1'b0;
      layer      <= LAYER_BASE;
      sent_codes <= '0;
      sent_mods  <= 8'd0;
      special    <= '0;
    end else if (s1_fire) begin
      queue      <= queue_next;
      mods       <= mods_next;
      semi_held  <= semi_held_next;
      semi_used  <= semi_used_next;
      layer      <= layer_next;
      sent_codes <= sent_codes_next;
      sent_mods  <= sent_mods_next;
      special    <= special_next;
    end
  end

  // ---------------- output register and second-beat slot ----------------
  // the update stage only fires with no second beat waiting, so a fire
  // replaces whatever the output register is handing off this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (s1_fire) begin
      report_valid <= (nres != 2'd0);
      pend_valid   <= (nres == 2'd2);
    end else if (report_valid && report_ready) begin
      report_valid <= pend_valid;
      pend_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      report      <= res0;
      pend_report <= res1;
    end else if (report_valid && report_ready && pend_valid) begin
      report <= pend_report;
    end
  end

  // ---------------- checks ----------------
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> report_valid)
    else $error("second beat waiting without a first beat");

  a_pend_first_not_last: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !report.last_of_run)
    else $error("first beat of a tap marked as last of run");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> key_ready)
    else $error("key channel stalled with empty update stage");

  a_tap_beat_order: assert property (@(posedge clk) disable iff (rst)
    (report_valid && report_ready && pend_valid) |=> (report_valid && report.last_of_run))
    else $error("second beat of a tap lost");

endmodule
